[rtl/amq_pkg.sv]
// ----------------------------------------------------------------------------
// amq_pkg
// Shared types, widths and the arctangent table for the attitude pipeline.
// ----------------------------------------------------------------------------
package amq_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int VEC_W     = 50;
  localparam int ANG_W     = 33;
  localparam int TRIG_W    = 33;
  localparam int RES_W     = 34;
  localparam int PROD_W    = 34;
  localparam int NORM_BIT  = 45;
  localparam int NORM_STEPS = 6;
  localparam int DIV_W     = 50;
  localparam int DEN_W     = 33;
  localparam int QUO_W     = 17;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
  localparam logic [31:0]              BA_HALF     = 32'h8000_0000;
  localparam logic signed [RES_W-1:0]  RES_QUARTER = 34'sh040000000;
  localparam logic signed [RES_W-1:0]  RES_HALF    = 34'sh080000000;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_word_t;

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_ba(input int unsigned i);
    case (i)
      0:  atan_ba = 32'h20000000;
      1:  atan_ba = 32'h12E4051E;
      2:  atan_ba = 32'h09FB385B;
      3:  atan_ba = 32'h051111D4;
      4:  atan_ba = 32'h028B0D43;
      5:  atan_ba = 32'h0145D7E1;
      6:  atan_ba = 32'h00A2F61E;
      7:  atan_ba = 32'h00517C55;
      8:  atan_ba = 32'h0028BE53;
      9:  atan_ba = 32'h00145F2F;
      10: atan_ba = 32'h000A2F98;
      11: atan_ba = 32'h000517CC;
      12: atan_ba = 32'h00028BE6;
      13: atan_ba = 32'h000145F3;
      14: atan_ba = 32'h0000A2FA;
      15: atan_ba = 32'h0000517D;
      16: atan_ba = 32'h000028BE;
      17: atan_ba = 32'h0000145F;
      18: atan_ba = 32'h00000A30;
      19: atan_ba = 32'h00000518;
      20: atan_ba = 32'h0000028C;
      21: atan_ba = 32'h00000146;
      22: atan_ba = 32'h000000A3;
      default: atan_ba = 32'h00000051;
    endcase
  endfunction

endpackage

[rtl/amq_sqrt.sv]
// ----------------------------------------------------------------------------
// amq_sqrt
// Floor square root, one root bit per cell, one word enters per cycle.
// ----------------------------------------------------------------------------
module amq_sqrt #(
  parameter int RAD_W  = 56,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);
  localparam int STEPS = RAD_W / 2;
  localparam int REM_W = STEPS + 3;

  logic                vld_s  [0:STEPS];
  logic [RAD_W-1:0]    rad_s  [0:STEPS];
  logic [REM_W-1:0]    rem_s  [0:STEPS];
  logic [STEPS-1:0]    root_s [0:STEPS];
  logic [SIDE_W-1:0]   side_s [0:STEPS];

  assign vld_s[0]  = in_vld;
  assign rad_s[0]  = in_rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    logic              vld_r;
    logic [RAD_W-1:0]  rad_r;
    logic [REM_W-1:0]  rem_r;
    logic [STEPS-1:0]  root_r;
    logic [SIDE_W-1:0] side_r;
    logic [REM_W-1:0]  rem2;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [STEPS-1:0]  root_nxt;

    always_comb begin
      rem2  = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
      trial = {1'b0, root_s[k], 2'b01};
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {root_s[k][STEPS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {root_s[k][STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      rad_r  <= {rad_s[k][RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_s[k];
    end

    assign vld_s[k+1]  = vld_r;
    assign rad_s[k+1]  = rad_r;
    assign rem_s[k+1]  = rem_r;
    assign root_s[k+1] = root_r;
    assign side_s[k+1] = side_r;
  end

  assign out_vld  = vld_s[STEPS];
  assign out_root = root_s[STEPS];
  assign out_side = side_s[STEPS];

endmodule

[rtl/amq_vec.sv]
// ----------------------------------------------------------------------------
// amq_vec
// Vectoring cordic: atan2(y, x) as a binary angle, with operand normalization.
// ----------------------------------------------------------------------------
module amq_vec #(
  parameter int STAGES = amq_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [amq_pkg::VEC_W-1:0]  in_y,
  input  logic signed [amq_pkg::VEC_W-1:0]  in_x,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_vld,
  output logic [31:0]                       out_ang,
  output logic [SIDE_W-1:0]                 out_side
);
  localparam int VW   = amq_pkg::VEC_W;
  localparam int NSH  = amq_pkg::NORM_STEPS;
  localparam int LAST = NSH + STAGES;

  logic                 vld_s  [0:LAST];
  logic signed [VW-1:0] x_s    [0:LAST];
  logic signed [VW-1:0] y_s    [0:LAST];
  logic        [VW-1:0] m_s    [0:NSH];
  logic        [31:0]   z_s    [0:STAGES];
  logic                 zero_s [0:LAST];
  logic                 neg_s  [0:LAST];
  logic [SIDE_W-1:0]    side_s [0:LAST];

  // operand prep
  logic                 p_vld_r;
  logic signed [VW-1:0] p_x_r, p_y_r;
  logic        [VW-1:0] p_m_r;
  logic                 p_zero_r, p_neg_r;
  logic [SIDE_W-1:0]    p_side_r;
  logic                 neg;
  logic signed [VW-1:0] xa, ya, ym;

  always_comb begin
    neg = (in_x < 0);
    xa  = neg ? -in_x : in_x;
    ya  = neg ? -in_y : in_y;
    ym  = (ya < 0) ? -ya : ya;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_x_r    <= xa;
    p_y_r    <= ya;
    p_m_r    <= (xa > ym) ? xa : ym;
    p_zero_r <= (in_x == 0) && (in_y == 0);
    p_neg_r  <= neg;
    p_side_r <= in_side;
  end

  assign vld_s[0]  = p_vld_r;
  assign x_s[0]    = p_x_r;
  assign y_s[0]    = p_y_r;
  assign m_s[0]    = p_m_r;
  assign zero_s[0] = p_zero_r;
  assign neg_s[0]  = p_neg_r;
  assign side_s[0] = p_side_r;
  assign z_s[0]    = '0;

  // normalization cells
  for (genvar j = 0; j < NSH; j++) begin : g_norm
    localparam int SH = 32 >> j;
    localparam logic [VW-1:0] LIM = VW'(1) << (amq_pkg::NORM_BIT + 1 - SH);
    logic                 vld_r;
    logic signed [VW-1:0] x_r, y_r;
    logic        [VW-1:0] m_r;
    logic                 zero_r, neg_r;
    logic [SIDE_W-1:0]    side_r;
    logic                 go;

    assign go = (m_s[j] < LIM);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[j];
      end
    end

    always_ff @(posedge clk) begin
      x_r    <= go ? (x_s[j] <<< SH) : x_s[j];
      y_r    <= go ? (y_s[j] <<< SH) : y_s[j];
      m_r    <= go ? (m_s[j] << SH) : m_s[j];
      zero_r <= zero_s[j];
      neg_r  <= neg_s[j];
      side_r <= side_s[j];
    end

    assign vld_s[j+1]  = vld_r;
    assign x_s[j+1]    = x_r;
    assign y_s[j+1]    = y_r;
    assign m_s[j+1]    = m_r;
    assign zero_s[j+1] = zero_r;
    assign neg_s[j+1]  = neg_r;
    assign side_s[j+1] = side_r;
  end

  // rotation cells
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam logic [31:0] ATAN = amq_pkg::atan_ba(i);
    logic                 vld_r;
    logic signed [VW-1:0] x_r, y_r, dx, dy;
    logic        [31:0]   z_r;
    logic                 zero_r, neg_r;
    logic [SIDE_W-1:0]    side_r;
    logic signed [VW-1:0] x_nxt, y_nxt;
    logic        [31:0]   z_nxt;

    always_comb begin
      dx = x_s[NSH+i] >>> i;
      dy = y_s[NSH+i] >>> i;
      if (y_s[NSH+i] > 0) begin
        x_nxt = x_s[NSH+i] + dy;
        y_nxt = y_s[NSH+i] - dx;
        z_nxt = z_s[i] + ATAN;
      end else begin
        x_nxt = x_s[NSH+i] - dy;
        y_nxt = y_s[NSH+i] + dx;
        z_nxt = z_s[i] - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[NSH+i];
      end
    end

    always_ff @(posedge clk) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_s[NSH+i];
      neg_r  <= neg_s[NSH+i];
      side_r <= side_s[NSH+i];
    end

    assign vld_s[NSH+i+1]  = vld_r;
    assign x_s[NSH+i+1]    = x_r;
    assign y_s[NSH+i+1]    = y_r;
    assign z_s[i+1]        = z_r;
    assign zero_s[NSH+i+1] = zero_r;
    assign neg_s[NSH+i+1]  = neg_r;
    assign side_s[NSH+i+1] = side_r;
  end

  assign out_vld  = vld_s[LAST];
  assign out_ang  = zero_s[LAST] ? 32'd0
                  : ((neg_s[LAST] ? amq_pkg::BA_HALF : 32'd0) + z_s[STAGES]);
  assign out_side = side_s[LAST];

endmodule

[rtl/amq_rot.sv]
// ----------------------------------------------------------------------------
// amq_rot
// Rotation cordic: sine and cosine in Q30 of a signed binary angle.
// ----------------------------------------------------------------------------
module amq_rot #(
  parameter int STAGES = amq_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [amq_pkg::ANG_W-1:0]   in_ang,
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_vld,
  output logic signed [amq_pkg::TRIG_W-1:0]  out_sin,
  output logic signed [amq_pkg::TRIG_W-1:0]  out_cos,
  output logic [SIDE_W-1:0]                  out_side
);
  localparam int TW = amq_pkg::TRIG_W;
  localparam int RW = amq_pkg::RES_W;

  logic                 vld_s  [0:STAGES];
  logic signed [TW-1:0] x_s    [0:STAGES];
  logic signed [TW-1:0] y_s    [0:STAGES];
  logic signed [RW-1:0] a_s    [0:STAGES];
  logic                 neg_s  [0:STAGES];
  logic [SIDE_W-1:0]    side_s [0:STAGES];

  // quadrant fold
  logic                 p_vld_r;
  logic signed [RW-1:0] p_a_r;
  logic                 p_neg_r;
  logic [SIDE_W-1:0]    p_side_r;
  logic signed [RW-1:0] a_ext, a_fold;
  logic                 neg;

  always_comb begin
    a_ext = {in_ang[amq_pkg::ANG_W-1], in_ang};
    if (a_ext > amq_pkg::RES_QUARTER) begin
      a_fold = amq_pkg::RES_HALF - a_ext;
      neg    = 1'b1;
    end else if (a_ext < -amq_pkg::RES_QUARTER) begin
      a_fold = -amq_pkg::RES_HALF - a_ext;
      neg    = 1'b1;
    end else begin
      a_fold = a_ext;
      neg    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_a_r    <= a_fold;
    p_neg_r  <= neg;
    p_side_r <= in_side;
  end

  assign vld_s[0]  = p_vld_r;
  assign x_s[0]    = amq_pkg::CORDIC_GAIN;
  assign y_s[0]    = '0;
  assign a_s[0]    = p_a_r;
  assign neg_s[0]  = p_neg_r;
  assign side_s[0] = p_side_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam logic signed [RW-1:0] ATAN = {2'b00, amq_pkg::atan_ba(i)};
    logic                 vld_r;
    logic signed [TW-1:0] x_r, y_r, dx, dy, x_nxt, y_nxt;
    logic signed [RW-1:0] a_r, a_nxt;
    logic                 neg_r;
    logic [SIDE_W-1:0]    side_r;

    always_comb begin
      dx = x_s[i] >>> i;
      dy = y_s[i] >>> i;
      if (a_s[i] >= 0) begin
        x_nxt = x_s[i] - dy;
        y_nxt = y_s[i] + dx;
        a_nxt = a_s[i] - ATAN;
      end else begin
        x_nxt = x_s[i] + dy;
        y_nxt = y_s[i] - dx;
        a_nxt = a_s[i] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      neg_r  <= neg_s[i];
      side_r <= side_s[i];
    end

    assign vld_s[i+1]  = vld_r;
    assign x_s[i+1]    = x_r;
    assign y_s[i+1]    = y_r;
    assign a_s[i+1]    = a_r;
    assign neg_s[i+1]  = neg_r;
    assign side_s[i+1] = side_r;
  end

  assign out_vld  = vld_s[STAGES];
  assign out_sin  = y_s[STAGES];
  assign out_cos  = neg_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
  assign out_side = side_s[STAGES];

endmodule

[rtl/amq_div.sv]
// ----------------------------------------------------------------------------
// amq_div
// Restoring divider, one quotient bit per cell, with an overflow flag.
// ----------------------------------------------------------------------------
module amq_div #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [amq_pkg::DIV_W-1:0]     in_num,
  input  logic [amq_pkg::DEN_W-1:0]     in_den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_vld,
  output logic [amq_pkg::QUO_W-1:0]     out_quo,
  output logic                          out_ovf,
  output logic [SIDE_W-1:0]             out_side
);
  localparam int DW = amq_pkg::DIV_W;
  localparam int NW = amq_pkg::DEN_W;
  localparam int QW = amq_pkg::QUO_W;

  logic              vld_s  [0:QW];
  logic [DW-1:0]     rem_s  [0:QW];
  logic [NW-1:0]     den_s  [0:QW];
  logic [QW-1:0]     quo_s  [0:QW];
  logic              ovf_s  [0:QW];
  logic [SIDE_W-1:0] side_s [0:QW];

  logic              p_vld_r;
  logic [DW-1:0]     p_rem_r;
  logic [NW-1:0]     p_den_r;
  logic              p_ovf_r;
  logic [SIDE_W-1:0] p_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_rem_r  <= in_num;
    p_den_r  <= in_den;
    p_ovf_r  <= (in_num >= (DW'(in_den) << QW));
    p_side_r <= in_side;
  end

  assign vld_s[0]  = p_vld_r;
  assign rem_s[0]  = p_rem_r;
  assign den_s[0]  = p_den_r;
  assign quo_s[0]  = '0;
  assign ovf_s[0]  = p_ovf_r;
  assign side_s[0] = p_side_r;

  for (genvar j = 0; j < QW; j++) begin : g_cell
    localparam int K = QW - 1 - j;
    logic              vld_r;
    logic [DW-1:0]     rem_r, sub;
    logic [NW-1:0]     den_r;
    logic [QW-1:0]     quo_r;
    logic              ovf_r;
    logic [SIDE_W-1:0] side_r;
    logic              fit;

    always_comb begin
      sub = DW'(den_s[j]) << K;
      fit = (rem_s[j] >= sub);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_r  <= fit ? (rem_s[j] - sub) : rem_s[j];
      quo_r  <= {quo_s[j][QW-2:0], fit};
      den_r  <= den_s[j];
      ovf_r  <= ovf_s[j];
      side_r <= side_s[j];
    end

    assign vld_s[j+1]  = vld_r;
    assign rem_s[j+1]  = rem_r;
    assign den_s[j+1]  = den_r;
    assign quo_s[j+1]  = quo_r;
    assign ovf_s[j+1]  = ovf_r;
    assign side_s[j+1] = side_r;
  end

  assign out_vld  = vld_s[QW];
  assign out_quo  = quo_s[QW];
  assign out_ovf  = ovf_s[QW];
  assign out_side = side_s[QW];

endmodule

[rtl/accel_mag_initial_quaternion.sv]
// ----------------------------------------------------------------------------
// accel_mag_initial_quaternion
// Unit attitude quaternion from one accelerometer and magnetometer sample.
// ----------------------------------------------------------------------------
// A fully pipelined chain of cordic, square root and divider cells: a new
// sample is taken on every cycle that start is high, busy is always low, and
// each word passes through the two square root chains (28 and 32 cells), two
// vectoring and two rotation cordics in series and the 18-stage divider before
// it comes out on out_valid. Results are shown for one cycle only; the
// receiver must take them as they come.
// ----------------------------------------------------------------------------
module accel_mag_initial_quaternion #(
  parameter int CORDIC_STAGES = amq_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  amq_pkg::in_word_t  in_data,
  output logic               out_valid,
  output amq_pkg::out_word_t out_data
);
  localparam int VW = amq_pkg::VEC_W;
  localparam int AW = amq_pkg::ANG_W;
  localparam int TW = amq_pkg::TRIG_W;
  localparam int PW = amq_pkg::PROD_W;
  localparam int DW = amq_pkg::DIV_W;

  function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    logic signed [PW+TW-1:0] p;
    p = a * b;
    return PW'(p >>> 30);
  endfunction

  assign busy = 1'b0;

  // tilt sums of squares
  logic                t1_vld_r;
  amq_pkg::in_word_t   t1_d_r;
  logic [31:0]         t1_ryz_r, t1_rxz_r;
  logic signed [31:0]  sq_ax, sq_ay, sq_az;

  always_comb begin
    sq_ax = in_data.accel_x * in_data.accel_x;
    sq_ay = in_data.accel_y * in_data.accel_y;
    sq_az = in_data.accel_z * in_data.accel_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
    end else begin
      t1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    t1_d_r   <= in_data;
    t1_ryz_r <= 32'(sq_ay) + 32'(sq_az);
    t1_rxz_r <= 32'(sq_ax) + 32'(sq_az);
  end

  logic        sa_vld;
  logic [27:0] sa_root, sb_root;
  logic [31:0] sa_side;
  logic [47:0] sb_side;

  amq_sqrt #(.RAD_W(56), .SIDE_W(32)) u_sqrt_roll (
    .clk, .rst_n,
    .in_vld  (t1_vld_r),
    .in_rad  ({t1_ryz_r, 24'd0}),
    .in_side ({t1_d_r.accel_x, t1_d_r.accel_y}),
    .out_vld (sa_vld),
    .out_root(sa_root),
    .out_side(sa_side)
  );

  amq_sqrt #(.RAD_W(56), .SIDE_W(48)) u_sqrt_pitch (
    .clk, .rst_n,
    .in_vld  (t1_vld_r),
    .in_rad  ({t1_rxz_r, 24'd0}),
    .in_side ({t1_d_r.mag_x, t1_d_r.mag_y, t1_d_r.mag_z}),
    .out_vld (),
    .out_root(sb_root),
    .out_side(sb_side)
  );

  // roll and pitch angles
  logic        vr_vld;
  logic [31:0] vr_ang, vp_ang;
  logic [31:0] vr_side;
  logic [15:0] vp_side;

  amq_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(32)) u_vec_roll (
    .clk, .rst_n,
    .in_vld  (sa_vld),
    .in_y    ({{(VW-28){sa_side[31]}}, sa_side[31:16], 12'd0}),
    .in_x    ({{(VW-28){1'b0}}, sa_root}),
    .in_side (sb_side[31:0]),
    .out_vld (vr_vld),
    .out_ang (vr_ang),
    .out_side(vr_side)
  );

  amq_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(16)) u_vec_pitch (
    .clk, .rst_n,
    .in_vld  (sa_vld),
    .in_y    ({{(VW-28){sa_side[15]}}, sa_side[15:0], 12'd0}),
    .in_x    ({{(VW-28){1'b0}}, sb_root}),
    .in_side (sb_side[47:32]),
    .out_vld (),
    .out_ang (vp_ang),
    .out_side(vp_side)
  );

  logic                 t2_vld_r;
  logic signed [AW-1:0] t2_roll_r, t2_pitch_r;
  logic [47:0]          t2_mag_r;
  logic signed [AW-1:0] roll_h, pitch_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_vld_r <= 1'b0;
    end else begin
      t2_vld_r <= vr_vld;
    end
  end

  always_ff @(posedge clk) begin
    t2_roll_r  <= -$signed({vr_ang[31], vr_ang});
    t2_pitch_r <= $signed({vp_ang[31], vp_ang});
    t2_mag_r   <= {vp_side, vr_side};
  end

  // half angles truncate toward zero
  always_comb begin
    roll_h  = (t2_roll_r + $signed({{(AW-1){1'b0}}, t2_roll_r[AW-1]})) >>> 1;
    pitch_h = (t2_pitch_r + $signed({{(AW-1){1'b0}}, t2_pitch_r[AW-1]})) >>> 1;
  end

  logic                 rr_vld;
  logic signed [TW-1:0] sr, cr, sp, cp, sr2, cr2, sp2, cp2;
  logic [47:0]          rr_side;

  amq_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(48)) u_rot_roll (
    .clk, .rst_n,
    .in_vld  (t2_vld_r),
    .in_ang  (t2_roll_r),
    .in_side (t2_mag_r),
    .out_vld (rr_vld),
    .out_sin (sr),
    .out_cos (cr),
    .out_side(rr_side)
  );

  amq_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_pitch (
    .clk, .rst_n,
    .in_vld  (t2_vld_r),
    .in_ang  (t2_pitch_r),
    .in_side (1'b0),
    .out_vld (),
    .out_sin (sp),
    .out_cos (cp),
    .out_side()
  );

  amq_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_roll_h (
    .clk, .rst_n,
    .in_vld  (t2_vld_r),
    .in_ang  (roll_h),
    .in_side (1'b0),
    .out_vld (),
    .out_sin (sr2),
    .out_cos (cr2),
    .out_side()
  );

  amq_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_pitch_h (
    .clk, .rst_n,
    .in_vld  (t2_vld_r),
    .in_ang  (pitch_h),
    .in_side (1'b0),
    .out_vld (),
    .out_sin (sp2),
    .out_cos (cp2),
    .out_side()
  );

  // tilt-compensated heading
  logic                   t3_vld_r;
  logic signed [PW-1:0]   t3_t_r;
  logic signed [VW-1:0]   t3_pmx_r, t3_pmy_r, t3_pmz_r;
  logic signed [16:0]     t3_msum_r;
  logic [4*TW-1:0]        t3_half_r;
  logic signed [2*TW-1:0] p_srcp;
  logic signed [15:0]     mx, my, mz;

  always_comb begin
    mx     = rr_side[47:32];
    my     = rr_side[31:16];
    mz     = rr_side[15:0];
    p_srcp = sr * cp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_vld_r <= 1'b0;
    end else begin
      t3_vld_r <= rr_vld;
    end
  end

  always_ff @(posedge clk) begin
    t3_t_r    <= PW'(p_srcp >>> 30);
    t3_pmx_r  <= mx * cr;
    t3_pmy_r  <= my * cp;
    t3_pmz_r  <= mz * sp;
    t3_msum_r <= {my[15], my} + {mz[15], mz};
    t3_half_r <= {sr2, cr2, sp2, cp2};
  end

  logic                 t4_vld_r;
  logic signed [VW-1:0] t4_hx_r, t4_hy_r;
  logic [4*TW-1:0]      t4_half_r;
  logic signed [50:0]   p_mt;

  assign p_mt = t3_msum_r * t3_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t4_vld_r <= 1'b0;
    end else begin
      t4_vld_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t4_hx_r   <= t3_pmx_r + VW'(p_mt);
    t4_hy_r   <= t3_pmy_r - t3_pmz_r;
    t4_half_r <= t3_half_r;
  end

  logic            vy_vld;
  logic [31:0]     yaw;
  logic [4*TW-1:0] vy_side;

  amq_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(4*TW)) u_vec_yaw (
    .clk, .rst_n,
    .in_vld  (t4_vld_r),
    .in_y    (t4_hx_r),
    .in_x    (t4_hy_r),
    .in_side (t4_half_r),
    .out_vld (vy_vld),
    .out_ang (yaw),
    .out_side(vy_side)
  );

  logic                 ry_vld;
  logic signed [TW-1:0] sy2, cy2;
  logic [4*TW-1:0]      ry_side;

  amq_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(4*TW)) u_rot_yaw (
    .clk, .rst_n,
    .in_vld  (vy_vld),
    .in_ang  ($signed({2'b00, yaw[31:1]})),
    .in_side (vy_side),
    .out_vld (ry_vld),
    .out_sin (sy2),
    .out_cos (cy2),
    .out_side(ry_side)
  );

  // quaternion products
  logic signed [TW-1:0] h_sr2, h_cr2, h_sp2, h_cp2;

  always_comb begin
    h_sr2 = ry_side[4*TW-1 -: TW];
    h_cr2 = ry_side[3*TW-1 -: TW];
    h_sp2 = ry_side[2*TW-1 -: TW];
    h_cp2 = ry_side[TW-1:0];
  end

  logic                 t5_vld_r;
  logic signed [PW-1:0] t5_cc_r, t5_ss_r, t5_sc_r, t5_cs_r;
  logic signed [TW-1:0] t5_sy_r, t5_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t5_vld_r <= 1'b0;
    end else begin
      t5_vld_r <= ry_vld;
    end
  end

  always_ff @(posedge clk) begin
    t5_cc_r <= mulq({h_cp2[TW-1], h_cp2}, h_cr2);
    t5_ss_r <= mulq({h_sp2[TW-1], h_sp2}, h_sr2);
    t5_sc_r <= mulq({h_sp2[TW-1], h_sp2}, h_cr2);
    t5_cs_r <= mulq({h_cp2[TW-1], h_cp2}, h_sr2);
    t5_sy_r <= sy2;
    t5_cy_r <= cy2;
  end

  logic                 t6_vld_r;
  logic signed [PW-1:0] t6_q_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t6_vld_r <= 1'b0;
    end else begin
      t6_vld_r <= t5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t6_q_r[0] <= mulq(t5_cc_r, t5_cy_r) + mulq(t5_ss_r, t5_sy_r);
    t6_q_r[1] <= mulq(t5_sc_r, t5_cy_r) - mulq(t5_cs_r, t5_sy_r);
    t6_q_r[2] <= mulq(t5_cs_r, t5_cy_r) + mulq(t5_sc_r, t5_sy_r);
    t6_q_r[3] <= mulq(t5_cc_r, t5_sy_r) - mulq(t5_ss_r, t5_cy_r);
  end

  // norm
  logic                 t7_vld_r;
  logic signed [PW-1:0] t7_q_r  [0:3];
  logic [63:0]          t7_sq_r [0:3];
  logic                 t8_vld_r;
  logic signed [PW-1:0] t8_q_r  [0:3];
  logic [63:0]          t8_s01_r, t8_s23_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t7_vld_r <= 1'b0;
      t8_vld_r <= 1'b0;
    end else begin
      t7_vld_r <= t6_vld_r;
      t8_vld_r <= t7_vld_r;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_sq
    logic signed [2*PW-1:0] sq;
    assign sq = t6_q_r[k] * t6_q_r[k];
    always_ff @(posedge clk) begin
      t7_q_r[k]  <= t6_q_r[k];
      t7_sq_r[k] <= sq[63:0];
      t8_q_r[k]  <= t7_q_r[k];
    end
  end

  always_ff @(posedge clk) begin
    t8_s01_r <= t7_sq_r[0] + t7_sq_r[1];
    t8_s23_r <= t7_sq_r[2] + t7_sq_r[3];
  end

  logic            sn_vld;
  logic [31:0]     norm;
  logic [4*PW-1:0] sn_side;

  amq_sqrt #(.RAD_W(64), .SIDE_W(4*PW)) u_sqrt_norm (
    .clk, .rst_n,
    .in_vld  (t8_vld_r),
    .in_rad  (t8_s01_r + t8_s23_r),
    .in_side ({t8_q_r[0], t8_q_r[1], t8_q_r[2], t8_q_r[3]}),
    .out_vld (sn_vld),
    .out_root(norm),
    .out_side(sn_side)
  );

  // scale to q2.14 with round half away from zero
  logic                         dv_vld [0:3];
  logic [amq_pkg::QUO_W-1:0]    quo    [0:3];
  logic                         ovf    [0:3];
  logic [1:0]                   dside  [0:3];
  logic [15:0]                  res    [0:3];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [PW-1:0] q;
    logic        [PW-1:0] qmag;
    logic        [DW-1:0] num;

    always_comb begin
      q    = sn_side[(4-k)*PW-1 -: PW];
      qmag = (q < 0) ? PW'(-q) : PW'(q);
      num  = {1'b0, qmag, 15'd0} + DW'(norm);
    end

    amq_div #(.SIDE_W(2)) u_div (
      .clk, .rst_n,
      .in_vld  (sn_vld),
      .in_num  (num),
      .in_den  ({norm, 1'b0}),
      .in_side ({q[PW-1], norm != 32'd0}),
      .out_vld (dv_vld[k]),
      .out_quo (quo[k]),
      .out_ovf (ovf[k]),
      .out_side(dside[k])
    );

    always_comb begin
      if (!dside[0][0]) begin
        res[k] = (k == 0) ? 16'sd16384 : 16'sd0;
      end else if (!dside[k][1]) begin
        res[k] = (ovf[k] || quo[k] > 17'd32767) ? 16'h7FFF : quo[k][15:0];
      end else begin
        res[k] = (ovf[k] || quo[k] > 17'd32768) ? 16'h8000 : -quo[k][15:0];
      end
    end
  end

  assign out_valid       = dv_vld[0];
  assign out_data.quat_w = res[0];
  assign out_data.quat_x = res[1];
  assign out_data.quat_y = res[2];
  assign out_data.quat_z = res[3];

endmodule

[tb/tb_accel_mag_initial_quaternion.sv]
// ----------------------------------------------------------------------------
// tb_accel_mag_initial_quaternion
// Sends directed and random sensor samples into the attitude pipeline. Each
// expected quaternion is computed by a predictor in the testbench and checked
// in order against the words the block puts out.
// ----------------------------------------------------------------------------
module tb_accel_mag_initial_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;
  localparam int LATENCY = 102 + 4 * STAGES;

  localparam longint BA_Q = 64'sd1 << 30;
  localparam longint BA_H = 64'sd1 << 31;
  localparam longint BA_F = 64'sd1 << 32;
  localparam longint GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint NORM_MIN = 64'sd1 << 45;

  class quat_scoreboard;
    amq_pkg::out_word_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function longint atan_turn(longint y, longint x);
      longint base, z, m, dx, dy;
      base = 0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        base = BA_H;
      end
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      while (m < NORM_MIN) begin
        x *= 2;
        y *= 2;
        m *= 2;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = floor_shr(x, i);
        dy = floor_shr(y, i);
        if (y > 0) begin
          x += dy;
          y -= dx;
          z += longint'(amq_pkg::atan_ba(i));
        end else begin
          x -= dy;
          y += dx;
          z -= longint'(amq_pkg::atan_ba(i));
        end
      end
      return (base + z) & 64'hFFFF_FFFF;
    endfunction

    static function longint wrap_signed(longint a);
      return (a >= BA_H) ? a - BA_F : a;
    endfunction

    static function void sin_cos(longint ang, output longint s, output longint c);
      bit flip;
      longint x, y, dx, dy;
      flip = 0;
      x = GAIN_Q30;
      y = 0;
      if (ang > BA_Q) begin
        ang = BA_H - ang;
        flip = 1;
      end else if (ang < -BA_Q) begin
        ang = -BA_H - ang;
        flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = floor_shr(x, i);
        dy = floor_shr(y, i);
        if (ang >= 0) begin
          x -= dy;
          y += dx;
          ang -= longint'(amq_pkg::atan_ba(i));
        end else begin
          x += dy;
          y -= dx;
          ang += longint'(amq_pkg::atan_ba(i));
        end
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    static function longint prod3(longint a, longint b, longint c);
      return floor_shr(floor_shr(a * b, 30) * c, 30);
    endfunction

    static function logic signed [15:0] scale_q14(longint q, longint n);
      longint num, r;
      num = q * 32768;
      r = (num + ((num >= 0) ? n : -n)) / (2 * n);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    static function amq_pkg::out_word_t attitude(amq_pkg::in_word_t w);
      longint ax, ay, az, mx, my, mz, roll, pitch, sr, cr, sp, cp, t, hx, hy;
      longint sr2, cr2, sp2, cp2, sy2, cy2, yaw;
      longint q[4];
      longint unsigned rt, sum, n;
      amq_pkg::out_word_t o;
      ax = w.accel_x;
      ay = w.accel_y;
      az = w.accel_z;
      mx = w.mag_x;
      my = w.mag_y;
      mz = w.mag_z;
      rt = int_sqrt(longint'(ay * ay + az * az) << 24);
      roll = -wrap_signed(atan_turn(ax * 4096, longint'(rt)));
      rt = int_sqrt(longint'(ax * ax + az * az) << 24);
      pitch = wrap_signed(atan_turn(ay * 4096, longint'(rt)));
      sin_cos(roll, sr, cr);
      sin_cos(pitch, sp, cp);
      t = floor_shr(sr * cp, 30);
      hy = my * cp - mz * sp;
      hx = mx * cr + my * t + mz * t;
      yaw = atan_turn(hx, hy);
      sin_cos(roll / 2, sr2, cr2);
      sin_cos(pitch / 2, sp2, cp2);
      sin_cos(yaw >> 1, sy2, cy2);
      q[0] = prod3(cp2, cr2, cy2) + prod3(sp2, sr2, sy2);
      q[1] = prod3(sp2, cr2, cy2) - prod3(cp2, sr2, sy2);
      q[2] = prod3(cp2, sr2, cy2) + prod3(sp2, cr2, sy2);
      q[3] = prod3(cp2, cr2, sy2) - prod3(sp2, sr2, cy2);
      sum = 0;
      for (int k = 0; k < 4; k++) sum += longint'(q[k] * q[k]);
      n = int_sqrt(sum);
      if (n == 0) begin
        o = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      end else begin
        o.quat_w = scale_q14(q[0], longint'(n));
        o.quat_x = scale_q14(q[1], longint'(n));
        o.quat_y = scale_q14(q[2], longint'(n));
        o.quat_z = scale_q14(q[3], longint'(n));
      end
      return o;
    endfunction

    task report_mismatch(string what, logic signed [15:0] want, logic signed [15:0] got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      errors++;
    endtask

    function void note_sample(amq_pkg::in_word_t w);
      pending.push_back(attitude(w));
    endfunction

    task check_word(amq_pkg::out_word_t got);
      amq_pkg::out_word_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", 0, got.quat_w);
        return;
      end
      want = pending.pop_front();
      if (got.quat_w !== want.quat_w) report_mismatch("quat_w", want.quat_w, got.quat_w);
      if (got.quat_x !== want.quat_x) report_mismatch("quat_x", want.quat_x, got.quat_x);
      if (got.quat_y !== want.quat_y) report_mismatch("quat_y", want.quat_y, got.quat_y);
      if (got.quat_z !== want.quat_z) report_mismatch("quat_z", want.quat_z, got.quat_z);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  amq_pkg::in_word_t in_data = '0;
  logic out_valid;
  amq_pkg::out_word_t out_data;
  quat_scoreboard sb;

  always #6 clk = ~clk;

  accel_mag_initial_quaternion #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_data);
  end

  function automatic logic signed [15:0] any_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 8192)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(amq_pkg::in_word_t w, bit allow_gaps);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(w);
  endtask

  task automatic send_fields(int a, int b, int c, int d, int e, int f);
    amq_pkg::in_word_t w;
    w = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f)};
    send_sample(w, 1);
  endtask

  task automatic wait_drained();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    amq_pkg::in_word_t w;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 4096, 4096, 0, 0);
    send_fields(4096, 0, 0, 0, 4096, 0);
    send_fields(-4096, 0, 0, 0, 0, 4096);
    send_fields(0, 4096, 0, 4096, 0, 0);
    send_fields(0, -4096, 0, -4096, 0, 0);
    send_fields(0, 0, -4096, -4096, 0, 0);
    send_fields(0, 0, 4096, 0, 0, 4096);
    send_fields(0, 0, 4096, 0, 0, 0);
    send_fields(0, 0, 4096, 0, -4096, 0);
    send_fields(32767, 32767, 32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, -32768, -32768, -32768);
    send_fields(-32768, 32767, 0, 32767, -32768, 0);
    send_fields(32767, 0, 0, 0, 0, 0);
    send_fields(0, 0, 0, 1, -1, 1);
    send_fields(1, 1, 1, -1, -1, -1);
    send_fields(-1, -1, -1, 1, 1, 1);
    wait_drained();

    for (int i = 0; i < 430; i++) begin
      w.accel_x = any_value();
      w.accel_y = any_value();
      w.accel_z = any_value();
      w.mag_x = any_value();
      w.mag_y = any_value();
      w.mag_z = any_value();
      send_sample(w, i < 330);
      if (i == 200) wait_drained();
    end
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/amq_pkg.sv
rtl/amq_sqrt.sv
rtl/amq_vec.sv
rtl/amq_rot.sv
rtl/amq_div.sv
rtl/accel_mag_initial_quaternion.sv
tb/tb_accel_mag_initial_quaternion.sv
